/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the rctdm_back module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define RCTDM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Signal that must never be true outside of reset.
`define RCTDM_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error(msg);

`endif

/* rtl/rctdm_pkg.sv */
// ----------------------------------------------------------------------------
// rctdm_pkg
// Types, constants and reciprocal constants shared by the throttle mixer blocks.
// ----------------------------------------------------------------------------
package rctdm_pkg;

  // Pulse measurement.
  localparam int TICK_SHIFT = 4;
  localparam int COUNT_BITS = 20;
  localparam int THR_W      = 11;
  localparam int CMP_W      = (COUNT_BITS - TICK_SHIFT > THR_W) ?
                              (COUNT_BITS - TICK_SHIFT) : THR_W;

  // Throttle bands in microseconds.
  localparam logic [THR_W-1:0] THR_MIN   = 11'd1100;
  localparam logic [THR_W-1:0] THR_MAX   = 11'd1900;
  localparam logic [THR_W-1:0] NEUTRAL   = 11'd1500;
  localparam logic [THR_W-1:0] STOP_LO   = 11'd1480;
  localparam logic [THR_W-1:0] STOP_HI   = 11'd1520;
  localparam logic [THR_W-1:0] TURN_LO   = 11'd1310;
  localparam logic [THR_W-1:0] TURN_HI   = 11'd1690;
  localparam logic [THR_W-1:0] RELAY_LO  = 11'd1490;
  localparam logic [THR_W-1:0] RELAY_HI  = 11'd1510;

  // Datapath widths.
  localparam int DAC_W   = 12;
  localparam int TDEV_W  = 9;   // |throttle - neutral| <= 400
  localparam int ANG_W   = 8;
  localparam int MAG_W   = 15;  // |top - floor| and friends
  localparam int PROD_W  = TDEV_W + MAG_W;
  localparam int DIVX_W  = 20;
  localparam int RCP_W   = 22;
  localparam int QUOT_W  = DIVX_W + RCP_W;
  localparam int SUM_W   = 18;
  localparam int TOP_W   = 16;

  // Division by constants as multiply by rounded-up reciprocal and shift.
  // The wheel divisor 400 is split into a shift by 4 and a divide by 25.
  localparam int RIGHT_DEN      = 23;
  localparam int LEFT_DEN       = 31;
  localparam int WHL_PRE_SHIFT  = 4;
  localparam int WHL_DEN_ODD    = 25;
  localparam int RCP_SHIFT_ANG  = 24;
  localparam int RCP_SHIFT_WHL  = 26;
  localparam logic [RCP_W-1:0] RCP_RIGHT =
    RCP_W'(((2 ** RCP_SHIFT_ANG) + RIGHT_DEN - 1) / RIGHT_DEN);
  localparam logic [RCP_W-1:0] RCP_LEFT =
    RCP_W'(((2 ** RCP_SHIFT_ANG) + LEFT_DEN - 1) / LEFT_DEN);
  localparam logic [RCP_W-1:0] RCP_WHL =
    RCP_W'(((2 ** RCP_SHIFT_WHL) + WHL_DEN_ODD - 1) / WHL_DEN_ODD);

  // Queue between the front and the mixer.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Result word layout.
  localparam int OUT_W = 40;

  // Configuration register reset values.
  localparam logic [4:0]       RST_DEAD_ZONE  = 5'd3;
  localparam logic [DAC_W-1:0] RST_FULL_SCALE = 12'd3300;
  localparam logic [DAC_W-1:0] RST_TURN_MIN   = 12'd2750;
  localparam logic [DAC_W-1:0] RST_TURN_FLOOR = 12'd300;

  typedef enum logic [1:0] {
    CFG_DEAD_ZONE,
    CFG_FULL_SCALE,
    CFG_TURN_MIN,
    CFG_TURN_FLOOR
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_STOP,
    OP_STRAIGHT,
    OP_TURN_RIGHT,
    OP_TURN_LEFT,
    OP_HOLD
  } mix_op_t;

  typedef struct packed {
    mix_op_t           op;
    logic              dir;
    logic [TDEV_W-1:0] t_dev;
    logic [ANG_W-1:0]  ang_mag;
    logic              relay;
    logic [THR_W-1:0]  thr_us;
  } mix_item_t;

  typedef struct packed {
    logic [DAC_W-1:0] full_scale;
    logic [DAC_W-1:0] turn_min;
    logic [DAC_W-1:0] turn_floor;
  } mix_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP_MUL,
    ST_TOP_DIV,
    ST_IN_MUL,
    ST_IN_DIV,
    ST_OUT_MUL,
    ST_OUT_DIV,
    ST_EMIT
  } back_state_t;

endpackage

/* rtl/rc_throttle_differential_mixer.sv */
// ----------------------------------------------------------------------------
// rc_throttle_differential_mixer
// RC throttle pulse decoder with a differential-drive DAC mixer.
// ----------------------------------------------------------------------------
// Each input transfer is one timer tick carrying the sampled RC pulse line and
// the steering angle, and each tick yields exactly one result transfer with
// the left and right wheel DAC words, the direction line, the relay line and
// the clamped throttle in microseconds. The front stage measures the pulse
// and classifies the tick in the cycle it is taken, so a tick is accepted in
// every cycle while the four-entry queue has room. The mixer behind the queue
// shares one multiplier and one reciprocal divider and steps a stop or held
// item straight to its emit state, a straight item through the output multiply
// and divide states, and a turning item through the top, inner and output
// multiply and divide states; that mixer sets the sustained rate, and once the
// queue fills the input is back-pressured to it. Configuration writes are taken
// in any cycle (cfg_ready is always high) and must only occur while the block
// is idle.
// ----------------------------------------------------------------------------
module rc_throttle_differential_mixer (
  input  logic        clk,
  input  logic        rst_n,
  // Tick input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] pulse_level, [8:1] steer_angle, rest zero
  // Result output.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] left wheel word, [23:12] right wheel word, [24] drive_dir,
  // [25] relay_on, [36:26] throttle_us, rest zero
  output logic [39:0] out_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import rctdm_pkg::*;

  logic [4:0]       dead_zone_r;
  logic [DAC_W-1:0] full_scale_r;
  logic [DAC_W-1:0] turn_min_r;
  logic [DAC_W-1:0] turn_floor_r;
  mix_cfg_t         mix_cfg;

  logic             push, q_full, q_empty, q_pop;
  mix_item_t        push_item, pop_item;

  // Configuration registers; every write transfer is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r  <= RST_DEAD_ZONE;
      full_scale_r <= RST_FULL_SCALE;
      turn_min_r   <= RST_TURN_MIN;
      turn_floor_r <= RST_TURN_FLOOR;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEAD_ZONE:  dead_zone_r  <= cfg_data[4:0];
        CFG_FULL_SCALE: full_scale_r <= cfg_data;
        CFG_TURN_MIN:   turn_min_r   <= cfg_data;
        CFG_TURN_FLOOR: turn_floor_r <= cfg_data;
      endcase
    end
  end

  assign mix_cfg.full_scale = full_scale_r;
  assign mix_cfg.turn_min   = turn_min_r;
  assign mix_cfg.turn_floor = turn_floor_r;

  // Pulse measurement and tick classification.
  rctdm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pulse_level (in_tdata[0]),
    .steer_angle ($signed(in_tdata[8:1])),
    .dead_zone   (dead_zone_r),
    .q_full      (q_full),
    .push        (push),
    .item        (push_item)
  );

  // Decoupling queue: the front keeps taking ticks while the mixer works, until the queue fills.
  rctdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // Wheel mixer and output register.
  rctdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (mix_cfg),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

/* rtl/rctdm_front.sv */
// ----------------------------------------------------------------------------
// rctdm_front
// Pulse width measurement and classification of each tick into a mixer op.
// ----------------------------------------------------------------------------
module rctdm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         pulse_level,
  input  logic signed [7:0]            steer_angle,
  input  logic [4:0]                   dead_zone,
  input  logic                         q_full,
  output logic                         push,
  output rctdm_pkg::mix_item_t         item
);
  import rctdm_pkg::*;

  logic [COUNT_BITS-1:0] pulse_ticks_r, pulse_ticks_nxt;
  logic [COUNT_BITS-1:0] latched_r, latched_nxt;
  logic                  last_level_r;
  logic                  falling;
  logic [COUNT_BITS-1:0] width_eff;
  logic [CMP_W-1:0]      us_raw;
  logic [THR_W-1:0]      thr;
  logic [THR_W-1:0]      dev;
  logic signed [8:0]     ang9, dz9;
  logic signed [8:0]     neg_ang;
  logic                  ang_right, ang_left, ang_center;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Count high ticks, saturating; latch the count on the falling edge.
  always_comb begin
    pulse_ticks_nxt = pulse_ticks_r;
    latched_nxt     = latched_r;
    if (pulse_level) begin
      if (!last_level_r) begin
        pulse_ticks_nxt = COUNT_BITS'(1);
      end else if (pulse_ticks_r != {COUNT_BITS{1'b1}}) begin
        pulse_ticks_nxt = pulse_ticks_r + COUNT_BITS'(1);
      end
    end else if (last_level_r) begin
      latched_nxt = pulse_ticks_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= '0;
      latched_r     <= '0;
      last_level_r  <= 1'b0;
    end else if (push) begin
      pulse_ticks_r <= pulse_ticks_nxt;
      latched_r     <= latched_nxt;
      last_level_r  <= pulse_level;
    end
  end

  // The new width already counts on the tick of the falling edge.
  assign falling   = !pulse_level && last_level_r;
  assign width_eff = falling ? pulse_ticks_r : latched_r;
  assign us_raw    = CMP_W'(width_eff >> TICK_SHIFT);

  always_comb begin
    priority if (us_raw == '0) begin
      thr = NEUTRAL;
    end else if (us_raw < CMP_W'(THR_MIN)) begin
      thr = THR_MIN;
    end else if (us_raw > CMP_W'(THR_MAX)) begin
      thr = THR_MAX;
    end else begin
      thr = us_raw[THR_W-1:0];
    end
  end

  assign dev = (thr >= NEUTRAL) ? (thr - NEUTRAL) : (NEUTRAL - thr);

  assign ang9       = {steer_angle[7], steer_angle};
  assign dz9        = $signed({4'b0, dead_zone});
  assign neg_ang    = -ang9;
  assign ang_right  = ang9 > dz9;
  assign ang_left   = ang9 < -dz9;
  assign ang_center = (ang9 > -dz9) && (ang9 < dz9);

  always_comb begin
    item.dir     = (thr <= STOP_HI);
    item.t_dev   = dev[TDEV_W-1:0];
    item.relay   = (thr > RELAY_LO) && (thr < RELAY_HI);
    item.thr_us  = thr;
    item.ang_mag = ang_left ? neg_ang[ANG_W-1:0] : ang9[ANG_W-1:0];
    priority if (thr >= STOP_LO && thr <= STOP_HI) begin
      item.op = OP_STOP;
    end else if ((thr >= TURN_LO) && (thr <= TURN_HI)) begin
      item.op = OP_STRAIGHT;
    end else if (ang_right) begin
      item.op = OP_TURN_RIGHT;
    end else if (ang_left) begin
      item.op = OP_TURN_LEFT;
    end else if (ang_center) begin
      item.op = OP_STRAIGHT;
    end else begin
      item.op = OP_HOLD;
    end
  end

endmodule

/* rtl/rctdm_queue.sv */
// ----------------------------------------------------------------------------
// rctdm_queue
// Short register queue between the tick classifier and the mixer.
// ----------------------------------------------------------------------------
module rctdm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rctdm_pkg::mix_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output rctdm_pkg::mix_item_t pop_item,
  output logic                 empty
);
  import rctdm_pkg::*;

  mix_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_push, do_pop;

  assign full     = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (Q_PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (Q_PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/rctdm_back.sv */
// ----------------------------------------------------------------------------
// rctdm_back
// Wheel mixer: one shared multiplier and one reciprocal divider, stepped by
// a small sequencer, plus the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rctdm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rctdm_pkg::mix_cfg_t          cfg,
  input  logic                         q_empty,
  input  rctdm_pkg::mix_item_t         q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rctdm_pkg::OUT_W-1:0]  out_data
);
  import rctdm_pkg::*;

  back_state_t             state_r, state_nxt, launch_st;
  mix_item_t               item_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_r;
  logic signed [TOP_W-1:0] top_r;
  logic [DAC_W-1:0]        inner_r, outer_r;
  logic [DAC_W-1:0]        held_left_r, held_right_r;
  logic                    held_dir_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  logic                    emit_ok, emit, launch, is_turn;
  logic [DAC_W-1:0]        base;
  logic [TDEV_W-1:0]       mul_a;
  logic signed [16:0]      diff;
  logic [16:0]             diff_abs;
  logic [PROD_W-1:0]       mul_prod;
  logic [DIVX_W-1:0]       div_x;
  logic [RCP_W-1:0]        div_rcp;
  logic [QUOT_W-1:0]       quot;
  logic [MAG_W-1:0]        q_mag;
  logic [DAC_W-1:0]        offset;
  logic signed [SUM_W-1:0] q_signed, sum;
  logic [DAC_W-1:0]        sat;
  logic [DAC_W-1:0]        left_w, right_w;
  logic                    dir_w;

  assign emit_ok = !out_valid_r || out_ready;
  assign emit    = (state_r == ST_EMIT) && emit_ok;
  assign launch  = ((state_r == ST_IDLE) || emit) && !q_empty;
  assign q_pop   = launch;

  always_comb begin
    unique case (q_item.op)
      OP_STRAIGHT:                launch_st = ST_OUT_MUL;
      OP_TURN_RIGHT, OP_TURN_LEFT: launch_st = ST_TOP_MUL;
      default:                    launch_st = ST_EMIT;
    endcase
  end

  // Next state.
  always_comb begin
    unique case (state_r)
      ST_IDLE:    state_nxt = launch ? launch_st : ST_IDLE;
      ST_TOP_MUL: state_nxt = ST_TOP_DIV;
      ST_TOP_DIV: state_nxt = ST_IN_MUL;
      ST_IN_MUL:  state_nxt = ST_IN_DIV;
      ST_IN_DIV:  state_nxt = ST_OUT_MUL;
      ST_OUT_MUL: state_nxt = ST_OUT_DIV;
      ST_OUT_DIV: state_nxt = ST_EMIT;
      ST_EMIT: begin
        priority if (!emit_ok) begin
          state_nxt = ST_EMIT;
        end else if (launch) begin
          state_nxt = launch_st;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls decoded from the state.
  assign is_turn = (item_r.op == OP_TURN_RIGHT) || (item_r.op == OP_TURN_LEFT);
  assign base    = is_turn ? cfg.turn_floor : '0;

  always_comb begin
    unique case (state_r)
      ST_TOP_MUL: begin
        mul_a = {1'b0, item_r.ang_mag};
        diff  = $signed({5'b0, cfg.turn_min}) - $signed({5'b0, cfg.full_scale});
      end
      ST_IN_MUL: begin
        mul_a = item_r.t_dev;
        diff  = {top_r[TOP_W-1], top_r} - $signed({5'b0, cfg.turn_floor});
      end
      default: begin
        mul_a = item_r.t_dev;
        diff  = $signed({5'b0, cfg.full_scale}) - $signed({5'b0, base});
      end
    endcase
  end

  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
  assign mul_prod = mul_a * diff_abs[MAG_W-1:0];

  // Truncating divide of the registered magnitude by 23, 31 or 400.
  always_comb begin
    if (state_r == ST_TOP_DIV) begin
      div_x   = prod_r[DIVX_W-1:0];
      div_rcp = (item_r.op == OP_TURN_LEFT) ? RCP_LEFT : RCP_RIGHT;
      offset  = cfg.full_scale;
    end else begin
      div_x   = prod_r[WHL_PRE_SHIFT +: DIVX_W];
      div_rcp = RCP_WHL;
      offset  = (state_r == ST_IN_DIV) ? cfg.turn_floor : base;
    end
  end

  assign quot     = div_x * div_rcp;
  assign q_mag    = (state_r == ST_TOP_DIV) ? quot[RCP_SHIFT_ANG +: MAG_W]
                                            : quot[RCP_SHIFT_WHL +: MAG_W];
  assign q_signed = neg_r ? -$signed({3'b0, q_mag}) : $signed({3'b0, q_mag});
  assign sum      = q_signed + $signed({6'b0, offset});

  always_comb begin
    priority if (sum[SUM_W-1]) begin
      sat = '0;
    end else if (sum > $signed(SUM_W'(4095))) begin
      sat = {DAC_W{1'b1}};
    end else begin
      sat = sum[DAC_W-1:0];
    end
  end

  // Wheel assignment for the finished item.
  always_comb begin
    unique case (item_r.op)
      OP_STRAIGHT: begin
        left_w = outer_r;     right_w = outer_r;      dir_w = item_r.dir;
      end
      OP_TURN_RIGHT: begin
        left_w = outer_r;     right_w = inner_r;      dir_w = item_r.dir;
      end
      OP_TURN_LEFT: begin
        left_w = inner_r;     right_w = outer_r;      dir_w = item_r.dir;
      end
      OP_HOLD: begin
        left_w = held_left_r; right_w = held_right_r; dir_w = held_dir_r;
      end
      default: begin
        left_w = '0;          right_w = '0;           dir_w = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      held_left_r  <= '0;
      held_right_r <= '0;
      held_dir_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r  <= 1'b1;
        held_left_r  <= left_w;
        held_right_r <= right_w;
        held_dir_r   <= dir_w;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      item_r <= q_item;
    end
    if (state_r == ST_TOP_MUL || state_r == ST_IN_MUL || state_r == ST_OUT_MUL) begin
      prod_r <= mul_prod;
      neg_r  <= diff[16];
    end
    if (state_r == ST_TOP_DIV) begin
      top_r <= sum[TOP_W-1:0];
    end
    if (state_r == ST_IN_DIV) begin
      inner_r <= sat;
    end
    if (state_r == ST_OUT_DIV) begin
      outer_r <= sat;
    end
    if (emit) begin
      out_data_r <= {3'b0, item_r.thr_us, item_r.relay, dir_w, right_w, left_w};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RCTDM_ASSERT(a_top_only_for_turns, clk, rst_n, (state_r == ST_TOP_MUL) |-> (item_r.op == OP_TURN_RIGHT || item_r.op == OP_TURN_LEFT), "angle scaling started for a non-turning item")
  `RCTDM_ASSERT(a_emit_sets_valid, clk, rst_n, (state_r == ST_EMIT && (!out_valid_r || out_ready)) |=> out_valid_r, "finished item did not reach the output register")
  `RCTDM_ASSERT(a_stop_is_zero, clk, rst_n, (emit && item_r.op == OP_STOP) |=> (out_data_r[2*DAC_W-1:0] == '0 && out_data_r[2*DAC_W] && held_dir_r), "stop item did not give zero wheels and reverse direction")

endmodule
